### src/ecs_pkg.sv
// shared types, codes and constants of the calibration save sequencer
package ecs_pkg;

  localparam int unsigned PAGE_BYTES    = 32;
  localparam int unsigned DEVICE_BYTES  = 32768;
  localparam int unsigned WRITE_WAIT_MS = 5;
  localparam int unsigned POLL_EXTRA_MS = 6;

  // 16-bit config address plus a carry bit for address + length
  localparam int ADDR_W     = 17;
  localparam int PLEN_W     = $clog2(PAGE_BYTES + 1);
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // request commands
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_RETRY = 2'd2;

  // bus operations
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_POLL  = 2'd2;

  // data sources
  localparam logic [1:0] SRC_INV = 2'd0;
  localparam logic [1:0] SRC_PAY = 2'd1;
  localparam logic [1:0] SRC_FIN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAY_LEN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_BASE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALIDATE_1ST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_VALUE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_VALUE     = 3'd6;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_FAIL = 2'd2
  } save_st_t;

  typedef enum logic [1:0] {
    PH_INV = 2'd0,
    PH_PAY = 2'd1,
    PH_FIN = 2'd2,
    PH_END = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    WR_IDLE = 2'd0,
    WR_WAIT = 2'd1,
    WR_DONE = 2'd2,
    WR_FAIL = 2'd3
  } wr_st_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic        permitted;
    logic        bus_ack;
  } ecs_in_t;

  typedef struct packed {
    logic [1:0]  save_status;
    logic [1:0]  phase_now;
    logic [1:0]  bus_op;
    logic [14:0] page_start;
    logic [5:0]  page_bytes;
    logic [1:0]  data_source;
    logic [14:0] data_offset;
  } ecs_out_t;

  typedef struct packed {
    logic [15:0] pay_len;
    logic [15:0] payload_base;
    logic [15:0] marker_base;
    logic        inv_first;
    logic        final_marker_enable;
    logic [7:0]  invalid_marker_value;
    logic [7:0]  final_marker_value;
  } ecs_cfg_t;

  typedef struct packed {
    save_st_t            save_st;
    phase_t              phase;
    wr_st_t              wr_st;
    logic [ADDR_W-1:0]   next_addr;
    logic [ADDR_W-1:0]   bytes_left;
    logic [ADDR_W-1:0]   src_off;
    logic [ADDR_W-1:0]   pend_addr;
    logic [PLEN_W-1:0]   pend_len;
    logic [TIME_W-1:0]   ready_time;
    logic                range_fail;
  } ecs_state_t;

  localparam ecs_state_t STATE_RESET = '{
    save_st:    ST_DONE,
    phase:      PH_END,
    wr_st:      WR_DONE,
    next_addr:  '0,
    bytes_left: '0,
    src_off:    '0,
    pend_addr:  '0,
    pend_len:   '0,
    ready_time: '0,
    range_fail: 1'b0
  };

endpackage

### src/ecs_cfg_regs.sv
// configuration register file of the calibration save sequencer
module ecs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ecs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ecs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ecs_pkg::ecs_cfg_t                cfg_o
);

  ecs_pkg::ecs_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecs_pkg::CFG_PAY_LEN:        cfg_r.pay_len              <= cfg_wdata;
        ecs_pkg::CFG_PAYLOAD_BASE:   cfg_r.payload_base         <= cfg_wdata;
        ecs_pkg::CFG_MARKER_BASE:    cfg_r.marker_base          <= cfg_wdata;
        ecs_pkg::CFG_INVALIDATE_1ST: cfg_r.inv_first            <= cfg_wdata[0];
        ecs_pkg::CFG_FINAL_ENABLE:   cfg_r.final_marker_enable  <= cfg_wdata[0];
        ecs_pkg::CFG_INVALID_VALUE:  cfg_r.invalid_marker_value <= cfg_wdata[7:0];
        ecs_pkg::CFG_FINAL_VALUE:    cfg_r.final_marker_value   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

### src/ecs_step.sv
// next-state and result logic for one sequencer request
module ecs_step (
  input  ecs_pkg::ecs_state_t st,
  input  ecs_pkg::ecs_in_t    req,
  input  ecs_pkg::ecs_cfg_t   cfg,
  output ecs_pkg::ecs_state_t st_nxt,
  output ecs_pkg::ecs_out_t   res
);

  function automatic ecs_pkg::phase_t phase_after_inv(ecs_pkg::ecs_cfg_t c);
    ecs_pkg::phase_t p;
    if (c.pay_len != '0) begin
      p = ecs_pkg::PH_PAY;
    end else if (c.final_marker_enable) begin
      p = ecs_pkg::PH_FIN;
    end else begin
      p = ecs_pkg::PH_END;
    end
    return p;
  endfunction

  // load address and length of the current phase and range check them
  function automatic ecs_pkg::ecs_state_t start_phase(ecs_pkg::ecs_state_t s,
                                                     ecs_pkg::ecs_cfg_t c);
    ecs_pkg::ecs_state_t     r;
    logic [ecs_pkg::ADDR_W-1:0] addr;
    logic [ecs_pkg::ADDR_W-1:0] len;
    r = s;
    if (s.phase == ecs_pkg::PH_PAY) begin
      addr = ecs_pkg::ADDR_W'(c.payload_base);
      len  = ecs_pkg::ADDR_W'(c.pay_len);
    end else begin
      addr = ecs_pkg::ADDR_W'(c.marker_base);
      len  = ecs_pkg::ADDR_W'(1);
    end
    r.next_addr  = '0;
    r.bytes_left = '0;
    r.src_off    = '0;
    r.pend_addr  = '0;
    r.pend_len   = '0;
    r.ready_time = '0;
    r.range_fail = 1'b0;
    if ((addr + len) > ecs_pkg::ADDR_W'(ecs_pkg::DEVICE_BYTES)) begin
      r.wr_st      = ecs_pkg::WR_FAIL;
      r.range_fail = 1'b1;
    end else begin
      r.next_addr  = addr;
      r.bytes_left = len;
      r.wr_st      = (len == '0) ? ecs_pkg::WR_DONE : ecs_pkg::WR_IDLE;
    end
    return r;
  endfunction

  logic [ecs_pkg::TIME_W-1:0] rdy_diff;
  logic [ecs_pkg::TIME_W-1:0] limit_diff;
  logic                       rdy_reached;
  logic                       limit_reached;
  logic [ecs_pkg::PLEN_W-1:0] page_off;
  logic [ecs_pkg::PLEN_W-1:0] room;
  logic [ecs_pkg::PLEN_W-1:0] plen;

  // wrap-safe time compares
  assign rdy_diff      = req.now_ms - st.ready_time;
  assign limit_diff    = req.now_ms - (st.ready_time + ecs_pkg::TIME_W'(ecs_pkg::POLL_EXTRA_MS));
  assign rdy_reached   = !rdy_diff[ecs_pkg::TIME_W-1];
  assign limit_reached = !limit_diff[ecs_pkg::TIME_W-1];

  // page-bounded chunk length
  assign page_off = ecs_pkg::PLEN_W'(st.next_addr % ecs_pkg::ADDR_W'(ecs_pkg::PAGE_BYTES));
  assign room     = ecs_pkg::PLEN_W'(ecs_pkg::PAGE_BYTES) - page_off;
  assign plen     = (ecs_pkg::ADDR_W'(room) > st.bytes_left) ?
                    ecs_pkg::PLEN_W'(st.bytes_left) : room;

  ecs_pkg::ecs_state_t        s;
  logic [1:0]                 op;
  logic [ecs_pkg::ADDR_W-1:0] pstart;
  logic [ecs_pkg::PLEN_W-1:0] pbytes;
  logic [1:0]                 src;
  logic [ecs_pkg::ADDR_W-1:0] offs;

  always_comb begin
    s      = st;
    op     = ecs_pkg::OP_NONE;
    pstart = '0;
    pbytes = '0;
    src    = ecs_pkg::SRC_INV;
    offs   = '0;
    unique case (req.command)
      ecs_pkg::CMD_BEGIN: begin
        s.phase      = cfg.inv_first ? ecs_pkg::PH_INV : phase_after_inv(cfg);
        s.save_st    = (s.phase == ecs_pkg::PH_END) ? ecs_pkg::ST_DONE : ecs_pkg::ST_BUSY;
        s.wr_st      = ecs_pkg::WR_DONE;
        s.next_addr  = '0;
        s.bytes_left = '0;
        s.src_off    = '0;
        s.pend_addr  = '0;
        s.pend_len   = '0;
        s.ready_time = '0;
        s.range_fail = 1'b0;
        if (s.phase != ecs_pkg::PH_END) begin
          s = start_phase(s, cfg);
        end
      end
      ecs_pkg::CMD_RETRY: begin
        if (st.save_st == ecs_pkg::ST_FAIL) begin
          // a range failure keeps the write state failed
          if (st.wr_st == ecs_pkg::WR_FAIL && !st.range_fail) begin
            s.wr_st = ecs_pkg::WR_IDLE;
          end
          s.save_st = ecs_pkg::ST_BUSY;
        end
      end
      ecs_pkg::CMD_STEP: begin
        if (st.save_st == ecs_pkg::ST_BUSY && req.permitted) begin
          case (st.wr_st)
            ecs_pkg::WR_WAIT: begin
              if (rdy_reached) begin
                op     = ecs_pkg::OP_POLL;
                pstart = st.pend_addr;
                if (!req.bus_ack) begin
                  if (limit_reached) begin
                    s.wr_st = ecs_pkg::WR_FAIL;
                  end
                end else begin
                  s.next_addr  = st.next_addr + ecs_pkg::ADDR_W'(st.pend_len);
                  s.src_off    = st.src_off + ecs_pkg::ADDR_W'(st.pend_len);
                  s.bytes_left = st.bytes_left - ecs_pkg::ADDR_W'(st.pend_len);
                  s.wr_st      = (s.bytes_left == '0) ? ecs_pkg::WR_DONE : ecs_pkg::WR_IDLE;
                end
              end
            end
            ecs_pkg::WR_IDLE: begin
              s.pend_addr = st.next_addr;
              s.pend_len  = plen;
              op          = ecs_pkg::OP_WRITE;
              pstart      = st.next_addr;
              pbytes      = plen;
              case (st.phase)
                ecs_pkg::PH_INV: src = ecs_pkg::SRC_INV;
                ecs_pkg::PH_PAY: src = ecs_pkg::SRC_PAY;
                default:         src = ecs_pkg::SRC_FIN;
              endcase
              offs = (st.phase == ecs_pkg::PH_PAY) ? st.src_off : '0;
              if (!req.bus_ack) begin
                s.wr_st = ecs_pkg::WR_FAIL;
              end else begin
                s.ready_time = req.now_ms + ecs_pkg::TIME_W'(ecs_pkg::WRITE_WAIT_MS);
                s.wr_st      = ecs_pkg::WR_WAIT;
              end
            end
            default: ;
          endcase

          if (s.wr_st == ecs_pkg::WR_FAIL) begin
            s.save_st = ecs_pkg::ST_FAIL;
          end else if (s.wr_st == ecs_pkg::WR_DONE) begin
            case (st.phase)
              ecs_pkg::PH_INV: s.phase = phase_after_inv(cfg);
              ecs_pkg::PH_PAY: s.phase = cfg.final_marker_enable ? ecs_pkg::PH_FIN
                                                                 : ecs_pkg::PH_END;
              default:         s.phase = ecs_pkg::PH_END;
            endcase
            if (s.phase == ecs_pkg::PH_END) begin
              s.save_st = ecs_pkg::ST_DONE;
            end else begin
              s = start_phase(s, cfg);
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign st_nxt          = s;
  assign res.save_status = s.save_st;
  assign res.phase_now   = s.phase;
  assign res.bus_op      = op;
  assign res.page_start  = pstart[14:0];
  assign res.page_bytes  = 6'(pbytes);
  assign res.data_source = src;
  assign res.data_offset = offs[14:0];

endmodule

### src/eeprom_calibration_save_sequencer.sv
// top level of the calibration save sequencer: request, state and result registers
// Calibration save sequencer for a paged EEPROM with acknowledge polling. Each
// request (begin, step or retry) is captured in an input register, runs through
// the step logic against the sequencer state, and lands in a result register.
// A new request is taken every cycle while the result register is free or
// draining.
// The state update (page chunk size, wrap-safe deadline compares, phase advance)
// is combinational, which allows that rate. A result waiting in the output
// register while out_stall is high holds the step logic; one more request can
// still be captured behind it. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata and take effect on the next request.
module eeprom_calibration_save_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ecs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ecs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ecs_pkg::ecs_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ecs_pkg::ecs_out_t               out_data
);

  ecs_pkg::ecs_cfg_t   cfg;
  ecs_pkg::ecs_state_t st_r;
  ecs_pkg::ecs_state_t st_nxt;
  ecs_pkg::ecs_out_t   res;
  ecs_pkg::ecs_in_t    in_req_r;
  ecs_pkg::ecs_out_t   out_req_r;
  logic                in_vld_r;
  logic                in_vld_nxt;
  logic                out_vld_r;
  logic                out_vld_nxt;
  logic                advance;
  logic                in_take;

  ecs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  ecs_step u_step (
    .st     (st_r),
    .req    (in_req_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // step runs when a request is held and the result slot is free or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= ecs_pkg::STATE_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r <= in_data;
    end
    if (advance) begin
      out_req_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_req_r;

`ifndef ASSERT_OFF
  a_done_iff_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.save_st == ecs_pkg::ST_DONE) == (st_r.phase == ecs_pkg::PH_END))
    else $error("save done and phase done disagree");

  a_range_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.range_fail |-> st_r.wr_st == ecs_pkg::WR_FAIL)
    else $error("range failure without failed write");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_vld_r && out_stall && in_vld_r)
    else $error("input stalled while result slot can drain");

  a_write_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_req_r.bus_op == ecs_pkg::OP_WRITE) |->
      (out_req_r.page_bytes != '0 &&
       out_req_r.page_bytes <= 6'(ecs_pkg::PAGE_BYTES)))
    else $error("page write length out of range");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("stepped request did not reach result register");
`endif

endmodule
